FILE: sv/aapt_pkg.sv
// Shared types, register indexes and constants of the addressed alert pattern timer.
package aapt_pkg;

    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned PAT_W   = 16;
    localparam int unsigned PRE_W   = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VAL_W   = 16;

    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_B     = 8'h62;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

    localparam logic signed [VAL_W-1:0] HUNDRED = 16'sd100;
    localparam logic signed [VAL_W-1:0] TEN     = 16'sd10;

    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS = 10'd6;
    localparam logic [PAT_W-1:0]  RST_BUZZER_ON      = 16'd35;
    localparam logic [PAT_W-1:0]  RST_BUZZER_PERIOD  = 16'd70;
    localparam logic [PAT_W-1:0]  RST_MOTOR_ON       = 16'd250;
    localparam logic [PAT_W-1:0]  RST_MOTOR_PERIOD   = 16'd500;
    localparam logic [PRE_W-1:0]  RST_PRESCALE       = 8'd10;
    localparam logic [PRE_W-1:0]  RST_TIMEOUT        = 8'd200;

    typedef enum logic [IDX_W-1:0] {
        REG_DEVICE_ADDRESS = 3'd0,
        REG_BUZZER_ON      = 3'd1,
        REG_BUZZER_PERIOD  = 3'd2,
        REG_MOTOR_ON       = 3'd3,
        REG_MOTOR_PERIOD   = 3'd4,
        REG_PRESCALE       = 3'd5,
        REG_TIMEOUT        = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] frame_byte0;
        logic [BYTE_W-1:0] frame_byte1;
        logic [BYTE_W-1:0] frame_byte2;
        logic [BYTE_W-1:0] frame_byte3;
        logic [BYTE_W-1:0] frame_byte4;
    } t_in_item;

    typedef struct packed {
        logic buzzer_drive;
        logic indicator_drive;
        logic motor_drive;
        logic alert_active;
    } t_out_item;

endpackage

FILE: sv/aapt_in_if.sv
// Valid/ready channel carrying one input item.
interface aapt_in_if;
    logic               valid;
    logic               ready;
    aapt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/aapt_out_if.sv
// Valid/ready channel carrying one result item.
interface aapt_out_if;
    logic                valid;
    logic                ready;
    aapt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/aapt_addr_match.sv
// Frame marker check and space-padded decimal address compare.
module aapt_addr_match (
    input  aapt_pkg::t_in_item                i_item,
    input  logic [aapt_pkg::ADDR_W-1:0]       i_device_address,
    output logic                              o_match
);
    logic signed [aapt_pkg::VAL_W-1:0] d1;
    logic signed [aapt_pkg::VAL_W-1:0] d2;
    logic signed [aapt_pkg::VAL_W-1:0] d3;
    logic signed [aapt_pkg::VAL_W-1:0] value;
    logic signed [aapt_pkg::VAL_W-1:0] dev;
    logic                              markers_ok;

    assign d1 = $signed({8'd0, i_item.frame_byte1}) - $signed({8'd0, aapt_pkg::CHAR_ZERO});
    assign d2 = $signed({8'd0, i_item.frame_byte2}) - $signed({8'd0, aapt_pkg::CHAR_ZERO});
    assign d3 = $signed({8'd0, i_item.frame_byte3}) - $signed({8'd0, aapt_pkg::CHAR_ZERO});
    assign dev = $signed({6'd0, i_device_address});

    always_comb begin
        if (i_item.frame_byte1 == aapt_pkg::CHAR_SPACE) begin
            if (i_item.frame_byte2 == aapt_pkg::CHAR_SPACE) begin
                value = d3;
            end else begin
                value = d2 * aapt_pkg::TEN + d3;
            end
        end else begin
            value = d1 * aapt_pkg::HUNDRED + d2 * aapt_pkg::TEN + d3;
        end
    end

    assign markers_ok = (i_item.frame_byte0 == aapt_pkg::CHAR_A)
                     && (i_item.frame_byte4 == aapt_pkg::CHAR_B);
    assign o_match = markers_ok && (value == dev);
endmodule

FILE: sv/addressed_alert_pattern_timer_core.sv
// Addressed alert pattern timer: pager alert state, blink patterns and timeout.
//
// Channels: i_in takes items (func 0 is a timer tick, func 1 a five-byte
// frame); o_out returns exactly one result per item with the buzzer,
// indicator and motor pin levels and the alert flag after that item.
// A frame with markers 'a'/'b' and a matching decimal address sets the alert;
// ticks run the blink counters and the prescaler/timeout that clear it.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at a
// clock edge; write only while no result is pending. Index 7 is ignored.
// Result: registered, and shown in the cycle after the input transfer.
// Throughput: one item per cycle while o_out is not held; all state updates
// are combinational between the accepted item and the result register.
// Stall: while o_out is held, the result register keeps its value; a new
// item is taken in the same cycle the pending result transfers.
// Reset (i_rst_n low, synchronous): registers take their default values,
// counters and alert clear, indicator level is 1, no result pending.
module addressed_alert_pattern_timer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aapt_in_if.sink                       i_in,
    aapt_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [aapt_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [aapt_pkg::CFG_W-1:0]    i_cfg_data
);
    logic [aapt_pkg::ADDR_W-1:0] r_dev_addr;
    logic [aapt_pkg::PAT_W-1:0]  r_buz_on;
    logic [aapt_pkg::PAT_W-1:0]  r_buz_per;
    logic [aapt_pkg::PAT_W-1:0]  r_mot_on;
    logic [aapt_pkg::PAT_W-1:0]  r_mot_per;
    logic [aapt_pkg::PRE_W-1:0]  r_pre_ticks;
    logic [aapt_pkg::PRE_W-1:0]  r_to_units;

    logic                        r_alert, n_alert;
    logic [aapt_pkg::PAT_W-1:0]  r_bcnt, n_bcnt;
    logic [aapt_pkg::PAT_W-1:0]  r_mcnt, n_mcnt;
    logic [aapt_pkg::PRE_W-1:0]  r_ps, n_ps;
    logic [aapt_pkg::PRE_W-1:0]  r_tc, n_tc;
    logic                        r_buz_lvl, n_buz_lvl;
    logic                        r_ind_lvl, n_ind_lvl;
    logic                        r_mot_lvl, n_mot_lvl;

    logic                        r_out_valid;
    aapt_pkg::t_out_item         r_out;

    logic                        in_fire;
    logic                        addr_hit;
    logic [aapt_pkg::PAT_W-1:0]  bcnt_inc;
    logic [aapt_pkg::PAT_W-1:0]  mcnt_inc;
    logic [aapt_pkg::PRE_W-1:0]  ps_inc;
    logic [aapt_pkg::PRE_W-1:0]  tc_step;

    aapt_addr_match u_addr (
        .i_item           (i_in.data),
        .i_device_address (r_dev_addr),
        .o_match          (addr_hit)
    );

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign bcnt_inc = r_bcnt + 16'd1;
    assign mcnt_inc = r_mcnt + 16'd1;
    assign ps_inc   = r_ps + 8'd1;

    always_comb begin
        n_alert   = r_alert;
        n_bcnt    = r_bcnt;
        n_mcnt    = r_mcnt;
        n_ps      = r_ps;
        n_tc      = r_tc;
        n_buz_lvl = r_buz_lvl;
        n_ind_lvl = r_ind_lvl;
        n_mot_lvl = r_mot_lvl;
        tc_step   = r_tc;
        if (i_in.data.func) begin
            if (addr_hit) begin
                n_alert = 1'b1;
            end
        end else begin
            n_ps = ps_inc;
            if (r_alert) begin
                if (bcnt_inc < r_buz_on) begin
                    n_buz_lvl = 1'b1;
                    n_ind_lvl = 1'b0;
                end else if (bcnt_inc < r_buz_per) begin
                    n_buz_lvl = 1'b0;
                    n_ind_lvl = 1'b1;
                end
                if (mcnt_inc < r_mot_on) begin
                    n_mot_lvl = 1'b1;
                end else if (mcnt_inc < r_mot_per) begin
                    n_mot_lvl = 1'b0;
                end
                n_bcnt = (bcnt_inc == r_buz_per) ? '0 : bcnt_inc;
                n_mcnt = (mcnt_inc == r_mot_per) ? '0 : mcnt_inc;
            end else begin
                n_buz_lvl = 1'b0;
                n_ind_lvl = 1'b1;
                n_mot_lvl = 1'b0;
                n_bcnt    = '0;
                n_mcnt    = '0;
            end
            if (ps_inc == r_pre_ticks) begin
                n_ps    = '0;
                tc_step = r_alert ? r_tc + 8'd1 : '0;
                if (tc_step == r_to_units) begin
                    n_tc    = '0;
                    n_alert = 1'b0;
                end else begin
                    n_tc = tc_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= aapt_pkg::RST_DEVICE_ADDRESS;
            r_buz_on    <= aapt_pkg::RST_BUZZER_ON;
            r_buz_per   <= aapt_pkg::RST_BUZZER_PERIOD;
            r_mot_on    <= aapt_pkg::RST_MOTOR_ON;
            r_mot_per   <= aapt_pkg::RST_MOTOR_PERIOD;
            r_pre_ticks <= aapt_pkg::RST_PRESCALE;
            r_to_units  <= aapt_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (aapt_pkg::t_cfg_idx'(i_cfg_idx))
                aapt_pkg::REG_DEVICE_ADDRESS: r_dev_addr  <= i_cfg_data[aapt_pkg::ADDR_W-1:0];
                aapt_pkg::REG_BUZZER_ON:      r_buz_on    <= i_cfg_data;
                aapt_pkg::REG_BUZZER_PERIOD:  r_buz_per   <= i_cfg_data;
                aapt_pkg::REG_MOTOR_ON:       r_mot_on    <= i_cfg_data;
                aapt_pkg::REG_MOTOR_PERIOD:   r_mot_per   <= i_cfg_data;
                aapt_pkg::REG_PRESCALE:       r_pre_ticks <= i_cfg_data[aapt_pkg::PRE_W-1:0];
                aapt_pkg::REG_TIMEOUT:        r_to_units  <= i_cfg_data[aapt_pkg::PRE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert     <= 1'b0;
            r_bcnt      <= '0;
            r_mcnt      <= '0;
            r_ps        <= '0;
            r_tc        <= '0;
            r_buz_lvl   <= 1'b0;
            r_ind_lvl   <= 1'b1;
            r_mot_lvl   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_alert     <= n_alert;
                r_bcnt      <= n_bcnt;
                r_mcnt      <= n_mcnt;
                r_ps        <= n_ps;
                r_tc        <= n_tc;
                r_buz_lvl   <= n_buz_lvl;
                r_ind_lvl   <= n_ind_lvl;
                r_mot_lvl   <= n_mot_lvl;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.buzzer_drive    <= n_buz_lvl;
            r_out.indicator_drive <= n_ind_lvl;
            r_out.motor_drive     <= n_mot_lvl;
            r_out.alert_active    <= n_alert;
        end
    end

    a_idle_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_in.data.func && !r_alert |=>
            !r_out.buzzer_drive && r_out.indicator_drive && !r_out.motor_drive)
        else $error("idle tick did not drive idle levels");

    a_buz_ind_complement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buz_lvl != r_ind_lvl)
        else $error("buzzer and indicator levels not complementary");

    a_frame_keeps_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.data.func |=>
            $stable(r_bcnt) && $stable(r_mcnt) && $stable(r_ps) && $stable(r_tc))
        else $error("frame changed a counter");

    a_alert_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_alert) |-> $past(in_fire && i_in.data.func))
        else $error("alert set without a frame transfer");
endmodule

FILE: test/addressed_alert_pattern_timer_core_tb.sv
// Testbench of the addressed alert pattern timer: directed and random traffic with a predictor.
module addressed_alert_pattern_timer_core_tb;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned IDLE_PCT     = 17;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam int unsigned STEADY_PHASE = 3;
    localparam int unsigned PAUSE_PHASE  = 5;
    localparam int unsigned PRINT_CAP    = 40;
    localparam logic [aapt_pkg::IDX_W-1:0] IDX_UNUSED = 3'd7;

    typedef enum int unsigned {
        MODE_SMALL,
        MODE_ODD,
        MODE_WIDE,
        MODE_MIN,
        MODE_MAX
    } t_cfg_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [aapt_pkg::IDX_W-1:0] i_cfg_idx;
    logic [aapt_pkg::CFG_W-1:0] i_cfg_data;

    aapt_in_if  in_ch ();
    aapt_out_if out_ch ();

    addressed_alert_pattern_timer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow registers and pager state
    logic [aapt_pkg::ADDR_W-1:0] dev_addr;
    logic [aapt_pkg::PAT_W-1:0]  buz_on, buz_per, mot_on, mot_per;
    logic [aapt_pkg::PRE_W-1:0]  pre_wrap, tmo_units;
    logic                        alert;
    logic [aapt_pkg::PAT_W-1:0]  buz_cnt, mot_cnt;
    logic [aapt_pkg::PRE_W-1:0]  pre_cnt, tmo_cnt;
    logic                        buz_lvl, ind_lvl, mot_lvl;

    aapt_pkg::t_out_item expected_pins_q[$];
    aapt_pkg::t_out_item pins_want;
    bit                  steady;
    int unsigned         cycles;
    int unsigned         mismatches;
    int unsigned         results_seen;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("addressed_alert_pattern_timer_core_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic check_pin(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %b want %b", results_seen, name, got,
                                      want));
        end
    endtask

    task automatic reset_shadow();
        dev_addr  = aapt_pkg::RST_DEVICE_ADDRESS;
        buz_on    = aapt_pkg::RST_BUZZER_ON;
        buz_per   = aapt_pkg::RST_BUZZER_PERIOD;
        mot_on    = aapt_pkg::RST_MOTOR_ON;
        mot_per   = aapt_pkg::RST_MOTOR_PERIOD;
        pre_wrap  = aapt_pkg::RST_PRESCALE;
        tmo_units = aapt_pkg::RST_TIMEOUT;
        alert     = 1'b0;
        buz_cnt   = '0;
        mot_cnt   = '0;
        pre_cnt   = '0;
        tmo_cnt   = '0;
        buz_lvl   = 1'b0;
        ind_lvl   = 1'b1;
        mot_lvl   = 1'b0;
    endtask

    function automatic int decoded_address(input aapt_pkg::t_in_item it);
        int d1, d2, d3;
        d1 = int'(it.frame_byte1) - int'(aapt_pkg::CHAR_ZERO);
        d2 = int'(it.frame_byte2) - int'(aapt_pkg::CHAR_ZERO);
        d3 = int'(it.frame_byte3) - int'(aapt_pkg::CHAR_ZERO);
        if (it.frame_byte1 == aapt_pkg::CHAR_SPACE) begin
            if (it.frame_byte2 == aapt_pkg::CHAR_SPACE) begin
                return d3;
            end
            return d2 * 10 + d3;
        end
        return d1 * 100 + d2 * 10 + d3;
    endfunction

    task automatic pager_step(input aapt_pkg::t_in_item it, output aapt_pkg::t_out_item pins);
        if (it.func) begin
            if (it.frame_byte0 == aapt_pkg::CHAR_A && it.frame_byte4 == aapt_pkg::CHAR_B &&
                decoded_address(it) == int'(dev_addr)) begin
                alert = 1'b1;
            end
        end else begin
            pre_cnt = pre_cnt + 8'd1;
            if (alert) begin
                buz_cnt = buz_cnt + 16'd1;
                mot_cnt = mot_cnt + 16'd1;
                if (buz_cnt < buz_on) begin
                    buz_lvl = 1'b1;
                    ind_lvl = 1'b0;
                end else if (buz_cnt < buz_per) begin
                    buz_lvl = 1'b0;
                    ind_lvl = 1'b1;
                end
                if (mot_cnt < mot_on) begin
                    mot_lvl = 1'b1;
                end else if (mot_cnt < mot_per) begin
                    mot_lvl = 1'b0;
                end
                if (buz_cnt == buz_per) begin
                    buz_cnt = '0;
                end
                if (mot_cnt == mot_per) begin
                    mot_cnt = '0;
                end
            end else begin
                ind_lvl = 1'b1;
                mot_lvl = 1'b0;
                buz_lvl = 1'b0;
                buz_cnt = '0;
                mot_cnt = '0;
            end
            if (pre_cnt == pre_wrap) begin
                pre_cnt = '0;
                if (alert) begin
                    tmo_cnt = tmo_cnt + 8'd1;
                end else begin
                    tmo_cnt = '0;
                end
                if (tmo_cnt == tmo_units) begin
                    tmo_cnt = '0;
                    alert   = 1'b0;
                end
            end
        end
        pins.buzzer_drive    = buz_lvl;
        pins.indicator_drive = ind_lvl;
        pins.motor_drive     = mot_lvl;
        pins.alert_active    = alert;
    endtask

    function automatic aapt_pkg::t_in_item make_frame(
        input logic [aapt_pkg::BYTE_W-1:0] b0, b1, b2, b3, b4);
        aapt_pkg::t_in_item it;
        it.func        = 1'b1;
        it.frame_byte0 = b0;
        it.frame_byte1 = b1;
        it.frame_byte2 = b2;
        it.frame_byte3 = b3;
        it.frame_byte4 = b4;
        return it;
    endfunction

    function automatic aapt_pkg::t_in_item make_tick(input logic [aapt_pkg::BYTE_W-1:0] fill);
        aapt_pkg::t_in_item it;
        it      = make_frame(fill, fill, fill, fill, fill);
        it.func = 1'b0;
        return it;
    endfunction

    function automatic aapt_pkg::t_in_item address_frame(input int unsigned a);
        int unsigned                 form;
        logic [aapt_pkg::BYTE_W-1:0] h, t, u;
        form = $urandom_range(2);
        h = aapt_pkg::CHAR_ZERO + 8'(a / 100);
        t = aapt_pkg::CHAR_ZERO + 8'((a / 10) % 10);
        u = aapt_pkg::CHAR_ZERO + 8'(a % 10);
        if (a < 10 && form == 0) begin
            return make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_SPACE, u,
                              aapt_pkg::CHAR_B);
        end
        if (a < 100 && form <= 1) begin
            return make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, t, u, aapt_pkg::CHAR_B);
        end
        return make_frame(aapt_pkg::CHAR_A, h, t, u, aapt_pkg::CHAR_B);
    endfunction

    function automatic aapt_pkg::t_in_item random_item();
        aapt_pkg::t_in_item it;
        int unsigned        roll;
        roll = $urandom_range(99);
        it = make_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        if (roll < 75) begin
            it.func = 1'b0;
        end else if (roll < 88) begin
            it = address_frame(dev_addr);
        end else if (roll < 94) begin
            it = address_frame($urandom_range(999));
        end else if (roll < 97) begin
            it.frame_byte0 = aapt_pkg::CHAR_A;
            it.frame_byte4 = aapt_pkg::CHAR_B;
        end
        return it;
    endfunction

    // Called and returns at a falling edge
    task automatic send_item(input aapt_pkg::t_in_item it);
        aapt_pkg::t_out_item pins;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        pager_step(it, pins);
        expected_pins_q.push_back(pins);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_pins_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [aapt_pkg::IDX_W-1:0] idx,
                             input logic [aapt_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            aapt_pkg::REG_DEVICE_ADDRESS: dev_addr  = value[aapt_pkg::ADDR_W-1:0];
            aapt_pkg::REG_BUZZER_ON:      buz_on    = value[aapt_pkg::PAT_W-1:0];
            aapt_pkg::REG_BUZZER_PERIOD:  buz_per   = value[aapt_pkg::PAT_W-1:0];
            aapt_pkg::REG_MOTOR_ON:       mot_on    = value[aapt_pkg::PAT_W-1:0];
            aapt_pkg::REG_MOTOR_PERIOD:   mot_per   = value[aapt_pkg::PAT_W-1:0];
            aapt_pkg::REG_PRESCALE:       pre_wrap  = value[aapt_pkg::PRE_W-1:0];
            aapt_pkg::REG_TIMEOUT:        tmo_units = value[aapt_pkg::PRE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure_patterns(input int unsigned a, bon, bper, mon, mper, pre, tmo);
        write_reg(aapt_pkg::REG_DEVICE_ADDRESS, 16'(a));
        write_reg(aapt_pkg::REG_BUZZER_ON, 16'(bon));
        write_reg(aapt_pkg::REG_BUZZER_PERIOD, 16'(bper));
        write_reg(aapt_pkg::REG_MOTOR_ON, 16'(mon));
        write_reg(aapt_pkg::REG_MOTOR_PERIOD, 16'(mper));
        write_reg(aapt_pkg::REG_PRESCALE, 16'(pre));
        write_reg(aapt_pkg::REG_TIMEOUT, 16'(tmo));
    endtask

    task automatic randomize_config(input t_cfg_mode mode);
        int unsigned a, bon, bper, mon, mper, pre, tmo;
        case ($urandom_range(2))
            0: a = $urandom_range(9);
            1: a = $urandom_range(99, 10);
            default: a = $urandom_range(999, 100);
        endcase
        case (mode)
            MODE_MIN: begin
                bon = 1; bper = 2; mon = 1; mper = 2; pre = 1; tmo = 1;
            end
            MODE_MAX: begin
                a = 999; bon = 65535; bper = 65535; mon = 65535; mper = 65535;
                pre = 255; tmo = 255;
            end
            MODE_ODD: begin
                bon  = $urandom_range(20, 2);
                bper = $urandom_range(bon, 2);
                mon  = $urandom_range(30, 2);
                mper = $urandom_range(mon, 2);
                pre  = $urandom_range(4, 1);
                tmo  = $urandom_range(4, 1);
            end
            MODE_WIDE: begin
                bon  = $urandom_range(65535, 1);
                bper = $urandom_range(65535, 2);
                mon  = $urandom_range(65535, 1);
                mper = $urandom_range(65535, 2);
                pre  = $urandom_range(255, 1);
                tmo  = $urandom_range(255, 1);
            end
            default: begin
                bon  = $urandom_range(8, 1);
                bper = $urandom_range(16, 2);
                mon  = $urandom_range(12, 1);
                mper = $urandom_range(24, 2);
                pre  = $urandom_range(6, 1);
                tmo  = $urandom_range(6, 1);
            end
        endcase
        configure_patterns(a, bon, bper, mon, mper, pre, tmo);
    endtask

    task automatic test_reset_state();
        send_item(make_tick(8'hFF));
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_SPACE,
                             aapt_pkg::CHAR_ZERO + 8'd6, aapt_pkg::CHAR_B));
        send_item(make_tick(8'h00));
        send_item(make_tick(8'hA5));
    endtask

    // One tick clears each alert, so every frame is seen on its own
    task automatic test_address_forms();
        wait_idle();
        write_reg(aapt_pkg::REG_TIMEOUT, 16'd1);
        write_reg(aapt_pkg::REG_PRESCALE, 16'(pre_cnt) + 16'd1);
        send_item(make_tick(8'h00));
        wait_idle();
        write_reg(aapt_pkg::REG_PRESCALE, 16'd1);
        write_reg(aapt_pkg::REG_DEVICE_ADDRESS, 16'd10);
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_SPACE,
                             aapt_pkg::CHAR_ZERO + 8'd10, aapt_pkg::CHAR_B));
        send_item(make_tick(8'h5A));
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_ZERO + 8'd1,
                             aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_B));
        send_item(make_tick(8'h00));
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_ZERO + 8'd1,
                             aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_B));
        send_item(make_tick(8'hFF));
        send_item(make_frame(aapt_pkg::CHAR_B, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_ZERO + 8'd1,
                             aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_B));
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_ZERO + 8'd1,
                             aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_A));
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_ZERO + 8'd1, aapt_pkg::CHAR_SPACE,
                             aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_B));
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_SPACE,
                             aapt_pkg::CHAR_ZERO - 8'd1, aapt_pkg::CHAR_B));
        send_item(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        write_reg(aapt_pkg::REG_DEVICE_ADDRESS, 16'd0);
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_SPACE, aapt_pkg::CHAR_SPACE,
                             aapt_pkg::CHAR_ZERO, aapt_pkg::CHAR_B));
        send_item(make_tick(8'h3C));
        wait_idle();
        write_reg(aapt_pkg::REG_DEVICE_ADDRESS, 16'd999);
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_ZERO + 8'd9,
                             aapt_pkg::CHAR_ZERO + 8'd9, aapt_pkg::CHAR_ZERO + 8'd9,
                             aapt_pkg::CHAR_B));
        send_item(make_tick(8'hC3));
    endtask

    task automatic test_ignored_index();
        wait_idle();
        write_reg(IDX_UNUSED, 16'hFFFF);
        send_item(make_frame(aapt_pkg::CHAR_A, aapt_pkg::CHAR_ZERO + 8'd9,
                             aapt_pkg::CHAR_ZERO + 8'd9, aapt_pkg::CHAR_ZERO + 8'd9,
                             aapt_pkg::CHAR_B));
        send_item(make_tick(8'h81));
    endtask

    task automatic test_random_traffic();
        t_cfg_mode mode;
        for (int unsigned p = 0; p < PHASES; p++) begin
            wait_idle();
            if (p == 0) begin
                mode = MODE_MIN;
            end else if (p == 1) begin
                mode = MODE_MAX;
            end else begin
                mode = t_cfg_mode'($urandom_range(MODE_WIDE));
            end
            randomize_config(mode);
            steady = (p == STEADY_PHASE);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
                send_item(random_item());
            end
            steady = 1'b0;
        end
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_pins_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", results_seen));
            end else begin
                pins_want = expected_pins_q.pop_front();
                check_pin("buzzer_drive", out_ch.data.buzzer_drive, pins_want.buzzer_drive);
                check_pin("indicator_drive", out_ch.data.indicator_drive,
                          pins_want.indicator_drive);
                check_pin("motor_drive", out_ch.data.motor_drive, pins_want.motor_drive);
                check_pin("alert_active", out_ch.data.alert_active, pins_want.alert_active);
            end
            results_seen++;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        steady       = 1'b0;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_address_forms();
        test_ignored_index();
        test_random_traffic();

        wait_idle();
        if (expected_pins_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_pins_q.size()));
        end
        if (mismatches == 0) begin
            $display("addressed_alert_pattern_timer_core_tb OK");
        end else begin
            $display("addressed_alert_pattern_timer_core_tb NOT OK");
        end
        $finish;
    end

endmodule
